@@ src/stg_pkg.sv @@
// Shared types, constants and codes of the step throttle sleep governor.
package stg_pkg;

    localparam int SCHED_ROWS_DEF = 8;

    localparam int STEP_W  = 32;
    localparam int LEVEL_W = 10;
    localparam int TEMP_W  = 12;
    localparam int FREQ_W  = 20;
    localparam int IVAL_W  = 16;
    localparam int SLEEP_W = 16;
    localparam int HELD_W  = 13;
    localparam int ROWI_W  = 3;
    localparam int CFGI_W  = 3;
    localparam int SRC_W   = 2;

    // bit-serial divider geometry
    localparam int DIV_DVD_W = 32;
    localparam int DIV_DVS_W = FREQ_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

    localparam logic [DIV_DVD_W-1:0] PERIOD_X2   = DIV_DVD_W'(2000000);
    localparam logic [DIV_DVD_W-1:0] SLEEP_CLAMP = DIV_DVD_W'(5000);

    // result source codes
    localparam logic [SRC_W-1:0] SRC_ROW    = 2'd0;
    localparam logic [SRC_W-1:0] SRC_RECALC = 2'd1;
    localparam logic [SRC_W-1:0] SRC_HELD   = 2'd2;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_BAT_THR  = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_TEMP_THR = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_BAT_HI   = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_BAT_LO   = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_TEMP_HI  = 3'd4;
    localparam logic [CFGI_W-1:0] CFG_TEMP_LO  = 3'd5;
    localparam logic [CFGI_W-1:0] CFG_IVAL     = 3'd6;
    localparam logic [CFGI_W-1:0] CFG_ENABLE   = 3'd7;

    typedef struct packed {
        logic [STEP_W-1:0]  first_step;
        logic               open_end;
        logic [STEP_W-1:0]  last_step;
        logic [SLEEP_W-1:0] sleep;
    } sched_data_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [SLEEP_W-1:0] sleep;
    } sched_res_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quo;
        logic [DIV_DVS_W-1:0] rem;
    } div_res_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_READ,
        SC_CHECK
    } scan_state_t;

    typedef enum logic [2:0] {
        G_IDLE,
        G_SCAN,
        G_MOD,
        G_POLICY,
        G_QUO,
        G_OUT
    } gov_state_t;

endpackage

@@ src/stg_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module stg_div
    import stg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_DVD_W-1:0] dividend,
    input  logic [DIV_DVS_W-1:0] divisor,
    output div_res_t             res
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_DVS_W-1:0] rem_reg, rem_next;

    logic [DIV_DVS_W:0]   trial;
    logic [DIV_DVS_W+1:0] diff;
    logic                 ge;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIV_DVD_W-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        ge    = ~diff[DIV_DVS_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_DVD_W - 1);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
            dvd_next = {dvd_reg[DIV_DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.quo  = dvd_reg;
    assign res.rem  = rem_reg;

endmodule

@@ src/stg_sched.sv @@
// Schedule table storage and row-by-row scan sequencer.
module stg_sched
    import stg_pkg::*;
#(
    parameter int SCHED_ROWS = SCHED_ROWS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ROWI_W-1:0] wr_index,
    input  logic              wr_valid,
    input  sched_data_t       wr_data,
    input  logic              scan_start,
    input  logic [STEP_W-1:0] step,
    output sched_res_t        res
);

    localparam int IDX_W = (SCHED_ROWS > 1) ? $clog2(SCHED_ROWS) : 1;
    localparam int CNT_W = $clog2(SCHED_ROWS + 1);

    logic        valid_reg [SCHED_ROWS];
    sched_data_t mem [SCHED_ROWS];

    sched_data_t rd_data_reg;
    logic        rd_valid_reg;

    scan_state_t state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] idx_inc;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_ok;

    assign wr_ok   = wr_en && (32'(wr_index) < SCHED_ROWS);
    assign wr_addr = IDX_W'(wr_index);
    assign rd_addr = idx_reg[IDX_W-1:0];
    assign idx_inc = idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCHED_ROWS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr_addr] <= wr_valid;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        res.done   = 1'b0;
        res.hit    = 1'b0;
        res.sleep  = rd_data_reg.sleep;
        case (state_reg)
            SC_IDLE:
            begin
                if (scan_start)
                begin
                    idx_next   = '0;
                    state_next = SC_READ;
                end
            end
            SC_READ:
            begin
                state_next = SC_CHECK;
            end
            SC_CHECK:
            begin
                if (!rd_valid_reg || (step < rd_data_reg.first_step))
                begin
                    res.done   = 1'b1;
                    state_next = SC_IDLE;
                end
                else if (rd_data_reg.open_end || (step <= rd_data_reg.last_step))
                begin
                    res.done   = 1'b1;
                    res.hit    = 1'b1;
                    state_next = SC_IDLE;
                end
                else if (idx_inc == CNT_W'(SCHED_ROWS))
                begin
                    res.done   = 1'b1;
                    state_next = SC_IDLE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = SC_READ;
                end
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

endmodule

@@ src/step_throttle_sleep_governor.sv @@
// Top level of the step throttle sleep governor: config, sequencer, output stage.
// A write request (mode 1) stores one schedule row; it yields no result. A
// query request (mode 0) scans the schedule row by row (registered table
// read, then compare), stopping at the first row that covers the step, the
// first invalid row or row starting past the step, or the last row. When no
// row covers the step and check_interval is nonzero, a shared bit-serial
// divider computes the step modulo the interval; if the step is a multiple
// of it and the chosen frequency f is nonzero, the divider runs again for
// the rounded sleep (2000000+f)/(2f). Other queries finish after the scan or
// the first division. One query is in flight at a time; the result sits in
// an output register so the next request is taken while it waits. The
// returned sleep is clamped to 5000 ms unless it comes straight from a
// schedule row. Configuration writes are always accepted and take effect at
// once; index 7 is the last register.
module step_throttle_sleep_governor
    import stg_pkg::*;
#(
    parameter int SCHED_ROWS = SCHED_ROWS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [STEP_W-1:0]        query_step,
    input  logic [LEVEL_W-1:0]       battery_level,
    input  logic signed [TEMP_W-1:0] cpu_temp,
    input  logic [ROWI_W-1:0]        row_index,
    input  logic                     row_valid,
    input  logic [STEP_W-1:0]        row_start,
    input  logic                     row_open_end,
    input  logic [STEP_W-1:0]        row_end,
    input  logic [SLEEP_W-1:0]       row_sleep,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SLEEP_W-1:0]       sleep_time,
    output logic [SRC_W-1:0]         source,
    // config write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFGI_W-1:0]        cfg_index,
    input  logic [FREQ_W-1:0]        cfg_data
);

    // config registers
    logic [LEVEL_W-1:0]       bat_thr_reg;
    logic signed [TEMP_W-1:0] temp_thr_reg;
    logic [FREQ_W-1:0]        bat_hi_reg;
    logic [FREQ_W-1:0]        bat_lo_reg;
    logic [FREQ_W-1:0]        temp_hi_reg;
    logic [FREQ_W-1:0]        temp_lo_reg;
    logic [IVAL_W-1:0]        ival_reg;
    logic [1:0]               enable_reg;

    // query operands, captured at accept
    logic [STEP_W-1:0]        step_reg;
    logic [LEVEL_W-1:0]       level_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    gov_state_t               state_reg, state_next;
    logic [HELD_W-1:0]        held_reg, held_next;
    logic [SLEEP_W-1:0]       res_sleep_reg, res_sleep_next;
    logic [SRC_W-1:0]         res_src_reg, res_src_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SLEEP_W-1:0]       sleep_time_reg, sleep_time_next;
    logic [SRC_W-1:0]         source_reg, source_next;

    logic                     in_acc;
    logic                     query_acc;
    logic                     write_acc;
    logic                     scan_start;
    sched_res_t               scan_res;
    sched_data_t              wr_data;

    logic                     div_start;
    logic [DIV_DVD_W-1:0]     div_dividend;
    logic [DIV_DVS_W-1:0]     div_divisor;
    div_res_t                 div_res;

    logic [FREQ_W-1:0]        freq_bat;
    logic [FREQ_W-1:0]        freq_temp;
    logic [FREQ_W-1:0]        freq_min;
    logic [DIV_DVD_W-1:0]     quo_clamped;

    assign in_ready  = (state_reg == G_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign query_acc = in_acc && !mode;
    assign write_acc = in_acc && mode;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign sleep_time = sleep_time_reg;
    assign source     = source_reg;

    assign wr_data.first_step = row_start;
    assign wr_data.open_end   = row_open_end;
    assign wr_data.last_step  = row_end;
    assign wr_data.sleep      = row_sleep;

    stg_sched #(
        .SCHED_ROWS (SCHED_ROWS)
    ) u_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (write_acc),
        .wr_index   (row_index),
        .wr_valid   (row_valid),
        .wr_data    (wr_data),
        .scan_start (scan_start),
        .step       (step_reg),
        .res        (scan_res)
    );

    stg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    // frequency policy: low freq only when the rule is on and its condition holds; the lower of the two wins
    always_comb
    begin
        freq_bat = bat_hi_reg;
        if (enable_reg[0] && (level_reg < bat_thr_reg))
        begin
            freq_bat = bat_lo_reg;
        end
        freq_temp = temp_hi_reg;
        if (enable_reg[1] && (temp_reg > temp_thr_reg))
        begin
            freq_temp = temp_lo_reg;
        end
        freq_min = (freq_bat < freq_temp) ? freq_bat : freq_temp;
    end

    assign quo_clamped = (div_res.quo > SLEEP_CLAMP) ? SLEEP_CLAMP : div_res.quo;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        res_sleep_next  = res_sleep_reg;
        res_src_next    = res_src_reg;
        scan_start      = 1'b0;
        div_start       = 1'b0;
        div_dividend    = DIV_DVD_W'(step_reg);
        div_divisor     = DIV_DVS_W'(ival_reg);
        out_valid_next  = out_valid_reg && !out_ready;
        sleep_time_next = sleep_time_reg;
        source_next     = source_reg;
        case (state_reg)
            G_IDLE:
            begin
                if (query_acc)
                begin
                    scan_start = 1'b1;
                    state_next = G_SCAN;
                end
            end
            G_SCAN:
            begin
                if (scan_res.done)
                begin
                    if (scan_res.hit)
                    begin
                        res_sleep_next = scan_res.sleep;
                        res_src_next   = SRC_ROW;
                        state_next     = G_OUT;
                    end
                    else if (ival_reg == '0)
                    begin
                        res_sleep_next = SLEEP_W'(held_reg);
                        res_src_next   = SRC_HELD;
                        state_next     = G_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = G_MOD;
                    end
                end
            end
            G_MOD:
            begin
                if (div_res.done)
                begin
                    if (div_res.rem == '0)
                    begin
                        state_next = G_POLICY;
                    end
                    else
                    begin
                        res_sleep_next = SLEEP_W'(held_reg);
                        res_src_next   = SRC_HELD;
                        state_next     = G_OUT;
                    end
                end
            end
            G_POLICY:
            begin
                if (freq_min == '0)
                begin
                    held_next      = '0;
                    res_sleep_next = '0;
                    res_src_next   = SRC_RECALC;
                    state_next     = G_OUT;
                end
                else
                begin
                    // round half up of 1e6/f
                    div_start    = 1'b1;
                    div_dividend = PERIOD_X2 + DIV_DVD_W'(freq_min);
                    div_divisor  = {freq_min, 1'b0};
                    state_next   = G_QUO;
                end
            end
            G_QUO:
            begin
                if (div_res.done)
                begin
                    held_next      = quo_clamped[HELD_W-1:0];
                    res_sleep_next = SLEEP_W'(quo_clamped[HELD_W-1:0]);
                    res_src_next   = SRC_RECALC;
                    state_next     = G_OUT;
                end
            end
            G_OUT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    sleep_time_next = res_sleep_reg;
                    source_next     = res_src_reg;
                    state_next      = G_IDLE;
                end
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= G_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_sleep_reg  <= res_sleep_next;
        res_src_reg    <= res_src_next;
        sleep_time_reg <= sleep_time_next;
        source_reg     <= source_next;
        if (query_acc)
        begin
            step_reg  <= query_step;
            level_reg <= battery_level;
            temp_reg  <= cpu_temp;
        end
    end

    // config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bat_thr_reg  <= LEVEL_W'(200);
            temp_thr_reg <= TEMP_W'(700);
            bat_hi_reg   <= '0;
            bat_lo_reg   <= '0;
            temp_hi_reg  <= '0;
            temp_lo_reg  <= '0;
            ival_reg     <= '0;
            enable_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BAT_THR:  bat_thr_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_TEMP_THR: temp_thr_reg <= cfg_data[TEMP_W-1:0];
                CFG_BAT_HI:   bat_hi_reg   <= cfg_data;
                CFG_BAT_LO:   bat_lo_reg   <= cfg_data;
                CFG_TEMP_HI:  temp_hi_reg  <= cfg_data;
                CFG_TEMP_LO:  temp_lo_reg  <= cfg_data;
                CFG_IVAL:     ival_reg     <= cfg_data[IVAL_W-1:0];
                CFG_ENABLE:   enable_reg   <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ src/stg_checker.sv @@
// Port-level checker for the governor, bound to the top level.
module stg_checker
    import stg_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     mode,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [SLEEP_W-1:0]       sleep_time,
    input logic [SRC_W-1:0]         source
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sleep_time) && $stable(source))
        else $error("stalled result changed");

    // recomputed or held sleep never exceeds the clamp
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && source != SRC_ROW |-> sleep_time <= SLEEP_W'(5000))
        else $error("sleep above clamp");

    // a row write produces no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && mode && !out_valid |=> !out_valid)
        else $error("result after row write");

    // an accepted query makes the block busy, so ready drops
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !mode |=> !in_ready)
        else $error("ready right after query");

endmodule

bind step_throttle_sleep_governor stg_checker u_stg_checker (.*);
